// ===== rtl/rti_pkg.sv =====
package rti_pkg;

  localparam int CW = 16;                 // coordinate width
  localparam int FB = 8;                  // fraction bits
  localparam int EW = CW + 1;             // edge / offset width
  localparam int HPW = CW + EW;           // h partial product
  localparam int HW = HPW + 1;            // h component
  localparam int QPW = 2 * EW;            // q partial product
  localparam int QW = QPW + 1;            // q component
  localparam int TW = EW + QW;            // dot product term
  localparam int DW = TW + 3;             // dot product sum
  localparam int TB = 41;                 // quotient bits, clamp at 2^(TB-1)
  localparam int THR_W = 16;
  localparam int VREG_W = 48;
  localparam int FRONT_STAGES = 7;
  localparam int DIV_STAGES = TB + 2;
  localparam int LAT = FRONT_STAGES + DIV_STAGES + 2;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_BEHIND   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    REG_V0  = 2'd0,
    REG_V1  = 2'd1,
    REG_V2  = 2'd2,
    REG_THR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    outcome_t             outcome;
    logic [CW-1:0]        distance;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } out_t;

  // ray data riding alongside the divider
  typedef struct packed {
    in_t      ray;
    outcome_t outcome;
  } side_t;

endpackage

// ===== rtl/rti_div.sv =====
module rti_div import rti_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DW-1:0]    num,      // t = num * 2^FB / den
  input  logic [DW-1:0]    den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [TB-1:0]    quot,     // clamped to 2^(TB-1)
  output logic [TAG_W-1:0] out_tag
);

  localparam int RW = DW + 1;
  localparam int NLW = TB;
  localparam logic [TB-1:0] T_MAX = TB'(1) << (TB - 1);

  logic             v_r   [TB+1];
  logic [RW-1:0]    rem_r [TB+1];
  logic [DW-1:0]    den_r [TB+1];
  logic [NLW-1:0]   nlo_r [TB+1];
  logic [TB-1:0]    q_r   [TB+1];
  logic             ovf_r [TB+1];
  logic [TAG_W-1:0] tag_r [TB+1];

  logic [DW-1:0]    rem0;
  logic [NLW-1:0]   nlo0;

  // numerator bits above the quotient range seed the remainder
  assign rem0 = num >> (TB - FB);
  assign nlo0 = {num[TB-FB-1:0], {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    rem_r[0] <= RW'(rem0);
    den_r[0] <= den;
    nlo_r[0] <= nlo0;
    q_r[0]   <= '0;
    ovf_r[0] <= rem0 >= den;
    tag_r[0] <= in_tag;
  end

  for (genvar k = 0; k < TB; k++) begin : g_bit
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {rem_r[k][RW-2:0], nlo_r[k][NLW-1]};
    assign ge    = trial >= RW'(den_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      rem_r[k+1] <= ge ? trial - RW'(den_r[k]) : trial;
      den_r[k+1] <= den_r[k];
      nlo_r[k+1] <= nlo_r[k] << 1;
      q_r[k+1]   <= {q_r[k][TB-2:0], ge};
      ovf_r[k+1] <= ovf_r[k];
      tag_r[k+1] <= tag_r[k];
    end
  end

  logic             v_out_r;
  logic [TB-1:0]    quot_r;
  logic [TAG_W-1:0] tag_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else begin
      v_out_r <= v_r[TB];
    end
    quot_r    <= (ovf_r[TB] || q_r[TB] > T_MAX) ? T_MAX : q_r[TB];
    tag_out_r <= tag_r[TB];
  end

  assign out_valid = v_out_r;
  assign quot      = quot_r;
  assign out_tag   = tag_out_r;

endmodule

// ===== rtl/ray_triangle_intersect.sv =====
// channel | ports                               | handshake
// input   | start, busy, in_data (in_t)         | taken when start && !busy
// result  | out_valid, out_data (out_t)         | one-cycle strobe, no backpressure
// config  | cfg_valid, cfg_ready, cfg_index/data| taken when cfg_valid && cfg_ready
//
// One ray per cycle; every ray gives one word.
// Latency is set by the one-bit-per-stage quotient pipeline (41 stages) plus
// the edge / cross / dot / test stages ahead of it and the point stages after.
// busy never rises and cfg_ready is always high.
// Synchronous reset clears the stage valid bits and sets the config registers to reset values.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  reg_idx_t          cfg_index,
  input  logic [VREG_W-1:0] cfg_data
);

  localparam logic signed [CW-1:0] P_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] P_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int PPW = TB + 1 + CW;

  logic [VREG_W-1:0] v0_r, v1_r, v2_r;
  logic [THR_W-1:0]  thr_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= '0;
      v1_r  <= '0;
      v2_r  <= '0;
      thr_r <= THR_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_V0:  v0_r  <= cfg_data;
        REG_V1:  v1_r  <= cfg_data;
        REG_V2:  v2_r  <= cfg_data;
        REG_THR: thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z;
  assign v0x = v0_r[CW-1:0];  assign v0y = v0_r[2*CW-1:CW];  assign v0z = v0_r[3*CW-1:2*CW];
  assign v1x = v1_r[CW-1:0];  assign v1y = v1_r[2*CW-1:CW];  assign v1z = v1_r[3*CW-1:2*CW];
  assign v2x = v2_r[CW-1:0];  assign v2y = v2_r[2*CW-1:CW];  assign v2z = v2_r[3*CW-1:2*CW];

  logic accept;
  assign accept = start && !busy;

  // stage 1: edges and origin offset
  logic                 v1s_r;
  in_t                  ray1_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] s_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1s_r <= 1'b0;
    else        v1s_r <= accept;
    ray1_r  <= in_data;
    e1_r[0] <= EW'(v1x) - EW'(v0x);
    e1_r[1] <= EW'(v1y) - EW'(v0y);
    e1_r[2] <= EW'(v1z) - EW'(v0z);
    e2_r[0] <= EW'(v2x) - EW'(v0x);
    e2_r[1] <= EW'(v2y) - EW'(v0y);
    e2_r[2] <= EW'(v2z) - EW'(v0z);
    s_r[0]  <= EW'(in_data.origin_x) - EW'(v0x);
    s_r[1]  <= EW'(in_data.origin_y) - EW'(v0y);
    s_r[2]  <= EW'(in_data.origin_z) - EW'(v0z);
  end

  // stage 2: cross product partials, h = dir x e2, q = s x e1
  logic                  v2s_r;
  in_t                   ray2_r;
  logic signed [EW-1:0]  e1b_r [3];
  logic signed [EW-1:0]  e2b_r [3];
  logic signed [EW-1:0]  sb_r  [3];
  logic signed [HPW-1:0] ph_r  [6];
  logic signed [QPW-1:0] pq_r  [6];

  always_ff @(posedge clk) begin
    if (!rst_n) v2s_r <= 1'b0;
    else        v2s_r <= v1s_r;
    ray2_r <= ray1_r;
    e1b_r  <= e1_r;
    e2b_r  <= e2_r;
    sb_r   <= s_r;
    ph_r[0] <= HPW'(ray1_r.dir_y * e2_r[2]);
    ph_r[1] <= HPW'(ray1_r.dir_z * e2_r[1]);
    ph_r[2] <= HPW'(ray1_r.dir_z * e2_r[0]);
    ph_r[3] <= HPW'(ray1_r.dir_x * e2_r[2]);
    ph_r[4] <= HPW'(ray1_r.dir_x * e2_r[1]);
    ph_r[5] <= HPW'(ray1_r.dir_y * e2_r[0]);
    pq_r[0] <= QPW'(s_r[1] * e1_r[2]);
    pq_r[1] <= QPW'(s_r[2] * e1_r[1]);
    pq_r[2] <= QPW'(s_r[2] * e1_r[0]);
    pq_r[3] <= QPW'(s_r[0] * e1_r[2]);
    pq_r[4] <= QPW'(s_r[0] * e1_r[1]);
    pq_r[5] <= QPW'(s_r[1] * e1_r[0]);
  end

  // stage 3: cross product components
  logic                 v3s_r;
  in_t                  ray3_r;
  logic signed [EW-1:0] e1c_r [3];
  logic signed [EW-1:0] e2c_r [3];
  logic signed [EW-1:0] sc_r  [3];
  logic signed [HW-1:0] h_r   [3];
  logic signed [QW-1:0] q_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3s_r <= 1'b0;
    else        v3s_r <= v2s_r;
    ray3_r <= ray2_r;
    e1c_r  <= e1b_r;
    e2c_r  <= e2b_r;
    sc_r   <= sb_r;
    for (int i = 0; i < 3; i++) begin
      h_r[i] <= HW'(ph_r[2*i]) - HW'(ph_r[2*i+1]);
      q_r[i] <= QW'(pq_r[2*i]) - QW'(pq_r[2*i+1]);
    end
  end

  // stage 4: dot product terms
  logic                 v4s_r;
  in_t                  ray4_r;
  logic signed [TW-1:0] tdet_r [3];
  logic signed [TW-1:0] tsh_r  [3];
  logic signed [TW-1:0] tdq_r  [3];
  logic signed [TW-1:0] teq_r  [3];
  logic signed [CW-1:0] dirc [3];

  assign dirc[0] = ray3_r.dir_x;
  assign dirc[1] = ray3_r.dir_y;
  assign dirc[2] = ray3_r.dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) v4s_r <= 1'b0;
    else        v4s_r <= v3s_r;
    ray4_r <= ray3_r;
    for (int i = 0; i < 3; i++) begin
      tdet_r[i] <= TW'(e1c_r[i] * h_r[i]);
      tsh_r[i]  <= TW'(sc_r[i] * h_r[i]);
      tdq_r[i]  <= TW'(dirc[i] * q_r[i]);
      teq_r[i]  <= TW'(e2c_r[i] * q_r[i]);
    end
  end

  // stage 5: dot product sums
  logic                 v5s_r;
  in_t                  ray5_r;
  logic signed [DW-1:0] det_r, sh_r, dq_r, eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5s_r <= 1'b0;
    else        v5s_r <= v4s_r;
    ray5_r <= ray4_r;
    det_r  <= DW'(tdet_r[0]) + DW'(tdet_r[1]) + DW'(tdet_r[2]);
    sh_r   <= DW'(tsh_r[0]) + DW'(tsh_r[1]) + DW'(tsh_r[2]);
    dq_r   <= DW'(tdq_r[0]) + DW'(tdq_r[1]) + DW'(tdq_r[2]);
    eq_r   <= DW'(teq_r[0]) + DW'(teq_r[1]) + DW'(teq_r[2]);
  end

  // stage 6: fold the sign of det into all four
  logic                 v6s_r;
  in_t                  ray6_r;
  logic signed [DW-1:0] deta_r, sha_r, dqa_r, eqa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6s_r <= 1'b0;
    else        v6s_r <= v5s_r;
    ray6_r <= ray5_r;
    deta_r <= det_r[DW-1] ? -det_r : det_r;
    sha_r  <= det_r[DW-1] ? -sh_r  : sh_r;
    dqa_r  <= det_r[DW-1] ? -dq_r  : dq_r;
    eqa_r  <= det_r[DW-1] ? -eq_r  : eq_r;
  end

  // stage 7: rejection tests in priority order
  logic                 v7s_r;
  side_t                side7_r;
  logic [DW-1:0]        num7_r, den7_r;
  outcome_t             oc_nxt;
  logic signed [DW-1:0] thr_s;

  assign thr_s = DW'(thr_r);

  always_comb begin
    if (deta_r < thr_s)                                      oc_nxt = OC_PARALLEL;
    else if (sha_r[DW-1] || sha_r > deta_r)                  oc_nxt = OC_U_OUT;
    else if (dqa_r[DW-1] || (sha_r + dqa_r) > deta_r)        oc_nxt = OC_V_OUT;
    else if (eqa_r[DW-1] || eqa_r == '0)                     oc_nxt = OC_BEHIND;
    else                                                     oc_nxt = OC_HIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7s_r <= 1'b0;
    else        v7s_r <= v6s_r;
    side7_r.ray     <= ray6_r;
    side7_r.outcome <= oc_nxt;
    num7_r <= eqa_r;
    den7_r <= deta_r;
  end

  // quotient pipeline
  logic          vd;
  logic [TB-1:0] t_q;
  side_t         side_d;

  rti_div #(.TAG_W($bits(side_t))) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7s_r),
    .num       (num7_r),
    .den       (den7_r),
    .in_tag    (side7_r),
    .out_valid (vd),
    .quot      (t_q),
    .out_tag   (side_d)
  );

  // point products t * dir
  logic                  vp_r;
  side_t                 sidep_r;
  logic [TB-1:0]         tp_r;
  logic signed [PPW-1:0] pp_r [3];
  logic signed [TB:0]    t_s;

  assign t_s = {1'b0, t_q};

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= vd;
    sidep_r  <= side_d;
    tp_r     <= t_q;
    pp_r[0]  <= PPW'(t_s * side_d.ray.dir_x);
    pp_r[1]  <= PPW'(t_s * side_d.ray.dir_y);
    pp_r[2]  <= PPW'(t_s * side_d.ray.dir_z);
  end

  // output word: floor shift, add origin, saturate
  logic signed [PPW-1:0] sum [3];
  logic signed [CW-1:0]  sat [3];
  logic signed [CW-1:0]  orgp [3];
  logic                  hit_p;
  out_t                  out_nxt, out_r;
  logic                  ov_r;

  assign orgp[0] = sidep_r.ray.origin_x;
  assign orgp[1] = sidep_r.ray.origin_y;
  assign orgp[2] = sidep_r.ray.origin_z;
  assign hit_p   = sidep_r.outcome == OC_HIT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = PPW'(orgp[i]) + (pp_r[i] >>> FB);
      if (sum[i] > PPW'(P_MAX))      sat[i] = P_MAX;
      else if (sum[i] < PPW'(P_MIN)) sat[i] = P_MIN;
      else                           sat[i] = sum[i][CW-1:0];
    end
    out_nxt.hit      = hit_p;
    out_nxt.outcome  = sidep_r.outcome;
    out_nxt.distance = '0;
    out_nxt.point_x  = '0;
    out_nxt.point_y  = '0;
    out_nxt.point_z  = '0;
    if (hit_p) begin
      out_nxt.distance = (tp_r > TB'({CW{1'b1}})) ? {CW{1'b1}} : tp_r[CW-1:0];
      out_nxt.point_x  = sat[0];
      out_nxt.point_y  = sat[1];
      out_nxt.point_z  = sat[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= vp_r;
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/rti_chk.sv =====
module rti_chk import rti_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data,
  input logic cfg_ready
);

  // every word traces back to a ray taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without matching ray");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit == (out_data.outcome == OC_HIT)))
    else $error("hit flag disagrees with outcome");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.distance == '0 && out_data.point_x == '0
      && out_data.point_y == '0 && out_data.point_z == '0))
    else $error("miss word carries nonzero payload");

  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block held off a ray or a config write");

endmodule

bind ray_triangle_intersect rti_chk u_rti_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

// ===== verif/tb_ray_triangle_intersect.sv =====
module tb_ray_triangle_intersect;
  import rti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_V0;
  logic [VREG_W-1:0] cfg_data = '0;

  ray_triangle_intersect u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // triangle and threshold as the predictor sees them
  logic [VREG_W-1:0] tri_v0 = '0, tri_v1 = '0, tri_v2 = '0;
  logic [THR_W-1:0] det_floor = THR_W'(1);

  in_t ray_q[$];
  out_t hit_q[$];
  int idle_pct = 0;
  int n_fail = 0, n_words = 0, n_rays = 0;
  int n_oc[5] = '{default: 0};

  function automatic longint sx(logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint floor_q(longint x);
    if (x >= 0) return x >>> FB;
    return -(((-x) - 1) >>> FB) - 1;
  endfunction

  function automatic logic [CW-1:0] sat_axis(longint o, longint d, longint t);
    longint p;
    p = o + floor_q(t * d);
    if (p < -32768) p = -32768;
    if (p > 32767) p = 32767;
    return p[CW-1:0];
  endfunction

  function automatic out_t trace_ray(in_t r);
    longint a0[3], a1[3], a2[3], e1[3], e2[3], h[3], s[3], q[3], o[3], d[3];
    longint det, sh, dq, eq, t;
    out_t res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      a0[i] = sx(tri_v0[16*i +: 16]);
      a1[i] = sx(tri_v1[16*i +: 16]);
      a2[i] = sx(tri_v2[16*i +: 16]);
      e1[i] = a1[i] - a0[i];
      e2[i] = a2[i] - a0[i];
    end
    o[0] = sx(r.origin_x); o[1] = sx(r.origin_y); o[2] = sx(r.origin_z);
    d[0] = sx(r.dir_x); d[1] = sx(r.dir_y); d[2] = sx(r.dir_z);
    for (int i = 0; i < 3; i++) s[i] = o[i] - a0[i];
    h[0] = d[1]*e2[2] - d[2]*e2[1];
    h[1] = d[2]*e2[0] - d[0]*e2[2];
    h[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
    sh = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
    dq = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    eq = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; sh = -sh; dq = -dq; eq = -eq;
    end
    if (det < longint'(det_floor)) res.outcome = OC_PARALLEL;
    else if (sh < 0 || sh > det) res.outcome = OC_U_OUT;
    else if (dq < 0 || sh + dq > det) res.outcome = OC_V_OUT;
    else if (eq <= 0) res.outcome = OC_BEHIND;
    else begin
      t = (eq * 256) / det;
      if (t > (longint'(1) << 40)) t = longint'(1) << 40;
      res.hit = 1'b1;
      res.outcome = OC_HIT;
      res.distance = (t > 65535) ? 16'hffff : t[15:0];
      res.point_x = sat_axis(o[0], d[0], t);
      res.point_y = sat_axis(o[1], d[1], t);
      res.point_z = sat_axis(o[2], d[2], t);
    end
    return res;
  endfunction

  // driver: a predicted word is queued at every edge where start && !busy
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      hit_q.push_back(trace_ray(in_data));
      n_rays++;
    end
    if (ray_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_data <= ray_q.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_words++;
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_data);
        n_fail++;
      end else begin
        out_t exp_w;
        exp_w = hit_q.pop_front();
        n_oc[exp_w.outcome]++;
        if (out_data !== exp_w) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_data);
          n_fail++;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [VREG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_V0: tri_v0 = val;
      REG_V1: tri_v1 = val;
      REG_V2: tri_v2 = val;
      default: det_floor = val[THR_W-1:0];
    endcase
  endtask

  function automatic logic [VREG_W-1:0] pack_v(int x, int y, int z);
    logic [VREG_W-1:0] v;
    v = {z[15:0], y[15:0], x[15:0]};
    return v;
  endfunction

  function automatic in_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    in_t r;
    r.origin_x = ox[15:0]; r.origin_y = oy[15:0]; r.origin_z = oz[15:0];
    r.dir_x = dx[15:0]; r.dir_y = dy[15:0]; r.dir_z = dz[15:0];
    return r;
  endfunction

  // mostly rays aimed at the triangle from in front and behind, some raw noise
  function automatic in_t rand_ray(int span);
    in_t r;
    int tx, ty;
    if ($urandom_range(9) < 2) begin
      r = {$urandom, $urandom, $urandom};
    end else begin
      tx = $urandom_range(2 * span) - span;
      ty = $urandom_range(2 * span) - span;
      r = mk_ray(tx + $urandom_range(64) - 32, ty + $urandom_range(64) - 32,
                 $urandom_range(8192) - 4096,
                 $urandom_range(512) - 256, $urandom_range(512) - 256,
                 ($urandom_range(1) ? 1 : -1) * $urandom_range(1024));
    end
    return r;
  endfunction

  task automatic drain();
    wait (ray_q.size() == 0 && !start);
    wait (hit_q.size() == 0);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic run_phase(int n, int span);
    for (int i = 0; i < n; i++) ray_q.push_back(rand_ray(span));
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // reset triangle is degenerate: everything parallel
    ray_q.push_back(mk_ray(0, 0, 256, 0, 0, -256));
    drain();
    // unit-ish triangle in z=0 plane
    write_reg(REG_V0, pack_v(0, 0, 0));
    write_reg(REG_V1, pack_v(1024, 0, 0));
    write_reg(REG_V2, pack_v(0, 1024, 0));
    write_reg(REG_THR, VREG_W'(1));
    ray_q.push_back(mk_ray(256, 256, 256, 0, 0, -256));       // hit
    ray_q.push_back(mk_ray(256, 256, 256, 256, 0, 0));        // parallel
    ray_q.push_back(mk_ray(-256, 256, 256, 0, 0, -256));      // u out
    ray_q.push_back(mk_ray(256, -256, 256, 0, 0, -256));      // v out
    ray_q.push_back(mk_ray(900, 900, 256, 0, 0, -256));       // u+v over
    ray_q.push_back(mk_ray(256, 256, -256, 0, 0, -256));      // behind
    ray_q.push_back(mk_ray(256, 256, 0, 0, 0, -256));         // t zero
    ray_q.push_back(mk_ray(0, 0, 256, 0, 0, -256));           // on vertex
    ray_q.push_back(mk_ray(32767, 32767, 32767, 0, 0, -1));   // extremes
    ray_q.push_back(mk_ray(-32768, -32768, -32768, 1, 1, 1));
    ray_q.push_back(mk_ray(256, 256, 32767, 0, 0, -1));       // big t
    ray_q.push_back(mk_ray(256, 256, 32767, 32767, 0, -1));   // point saturates
    ray_q.push_back(mk_ray(256, 256, 32767, -32768, 0, -1));
    ray_q.push_back(mk_ray(256, 256, 1, 0, 0, -32768));       // tiny t
    ray_q.push_back(mk_ray(256, 256, -256, 0, 0, 256));       // from back face
    ray_q.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
    drain();
    idle_pct = 11;
    run_phase(180, 1024);
    // extreme vertices, high threshold
    write_reg(REG_V0, pack_v(-32768, -32768, 32767));
    write_reg(REG_V1, pack_v(32767, -32768, -32768));
    write_reg(REG_V2, pack_v(-32768, 32767, 0));
    write_reg(REG_THR, VREG_W'(16'hffff));
    idle_pct = 78;
    run_phase(60, 32767);
    write_reg(REG_THR, VREG_W'(16'h0100));
    write_reg(REG_V0, pack_v(-512, -512, 128));
    write_reg(REG_V1, pack_v(512, -512, -128));
    write_reg(REG_V2, pack_v(0, 768, 0));
    run_phase(120, 768);
    idle_pct = 0;
    write_reg(REG_V0, VREG_W'({$urandom, $urandom}));
    write_reg(REG_V1, pack_v(-1, 0, 0));
    write_reg(REG_V2, pack_v(0, -1, 32767));
    write_reg(REG_THR, VREG_W'(1));
    run_phase(40, 4096);
    write_reg(REG_V0, pack_v(0, 0, 0));
    write_reg(REG_V1, pack_v(2048, 0, 512));
    write_reg(REG_V2, pack_v(0, 2048, -512));
    run_phase(150, 2048);
    $display("rays %0d words %0d: hit %0d parallel %0d u_out %0d v_out %0d behind %0d",
             n_rays, n_words, n_oc[0], n_oc[1], n_oc[2], n_oc[3], n_oc[4]);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
